// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define DTQ_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("dtq assertion failed");

// Next-cycle implication, disabled during reset
`define DTQ_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("dtq assertion failed");

`endif

// ----- hdl/dtq_pkg.sv -----
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and codes of the deadline timer queue.
// ----------------------------------------------------------------------------
`default_nettype none
package dtq_pkg;
    localparam int CAPACITY_DEF = 16;
    localparam logic [15:0] MAX_WAIT_RESET = 16'd1000;

    // request mode codes
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_TICK   = 2'd1;
    localparam logic [1:0] MODE_CANCEL = 2'd2;
    localparam logic [1:0] MODE_NOP    = 2'd3;

    // result kind codes
    localparam logic [2:0] KIND_ADDED  = 3'd0;
    localparam logic [2:0] KIND_FULL   = 3'd1;
    localparam logic [2:0] KIND_FIRED  = 3'd2;
    localparam logic [2:0] KIND_CANCEL = 3'd3;
    localparam logic [2:0] KIND_TICK   = 3'd4;

    typedef enum logic [1:0] {OP_ADD, OP_TICK, OP_CANCEL, OP_NOP} op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] timer_delay;
        logic [15:0] target_handle;
    } cmd_t;
endpackage
`default_nettype wire

// ----- hdl/dtq_req_if.sv -----
// ----------------------------------------------------------------------------
// dtq_req_if
// Request channel: one beat per timer command.
// ----------------------------------------------------------------------------
`default_nettype none
interface dtq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] timer_delay;
    logic [15:0] target_handle;

    modport source (output valid, mode, timer_delay, target_handle, input ready);
    modport sink   (input valid, mode, timer_delay, target_handle, output ready);
endinterface
`default_nettype wire

// ----- hdl/dtq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// dtq_rsp_if
// Result channel: one beat per result.
// ----------------------------------------------------------------------------
`default_nettype none
interface dtq_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] handle;
    logic [15:0] wait_ms;
    logic        last;

    modport source (output valid, kind, handle, wait_ms, last, input ready);
    modport sink   (input valid, kind, handle, wait_ms, last, output ready);
endinterface
`default_nettype wire

// ----- hdl/dtq_cfg_if.sv -----
// ----------------------------------------------------------------------------
// dtq_cfg_if
// Configuration write channel for max_wait_ms.
// ----------------------------------------------------------------------------
`default_nettype none
interface dtq_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/dtq_front.sv -----
// ----------------------------------------------------------------------------
// dtq_front
// Accepts request beats, decodes the mode and buffers commands in a
// two-entry queue toward the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module dtq_front (
    input  wire logic       clk,
    input  wire logic       rst_n,
    dtq_req_if.sink         req,
    output dtq_pkg::cmd_t   cmd,
    output logic            cmd_valid,
    input  wire logic       cmd_ready
);
    import dtq_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    cmd_t       dec;
    logic       push;
    logic       pop;

    // mode decode
    always_comb
    begin
        dec.timer_delay   = req.timer_delay;
        dec.target_handle = req.target_handle;
        case (req.mode)
            MODE_ADD:    dec.op = OP_ADD;
            MODE_TICK:   dec.op = OP_TICK;
            MODE_CANCEL: dec.op = OP_CANCEL;
            default:     dec.op = OP_NOP;
        endcase
    end

    assign req.ready = (cnt_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= dec;
    end
endmodule
`default_nettype wire

// ----- hdl/dtq_back.sv -----
// ----------------------------------------------------------------------------
// dtq_back
// Sequencer over the sorted timer cells: insert, cancel, tick and pop,
// wait computation and the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none
module dtq_back #(
    parameter int CAPACITY = dtq_pkg::CAPACITY_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dtq_pkg::cmd_t cmd,
    input  wire logic        cmd_valid,
    output logic             cmd_ready,
    input  wire logic [15:0] max_wait,
    dtq_rsp_if.source        rsp
);
    import dtq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {S_IDLE, S_SUM, S_INS, S_EXEC, S_WAIT, S_POP, S_EMIT} state_t;

    state_t         state_reg;
    op_t            op_reg;
    logic [31:0]    delay_reg;
    logic [15:0]    target_reg;
    logic [63:0]    time_reg;
    logic [15:0]    next_handle_reg;
    logic [CW-1:0]  count_reg;
    logic [63:0]    dl_reg;
    logic [15:0]    wait_reg;
    logic [2:0]     pend_kind_reg;
    logic [15:0]    pend_handle_reg;
    logic [63:0]    dead_reg [CAPACITY];
    logic [15:0]    hdl_reg  [CAPACITY];
    logic           canc_reg [CAPACITY];

    logic           out_valid_reg;
    logic [2:0]     out_kind_reg;
    logic [15:0]    out_handle_reg;
    logic [15:0]    out_wait_reg;
    logic           out_last_reg;

    logic [CAPACITY-1:0] vld;
    logic [CAPACITY-1:0] gt;
    logic [CAPACITY-1:0] due;
    logic [CAPACITY-1:0] sel;
    logic [63:0]    ins_dead [CAPACITY];
    logic [15:0]    ins_hdl  [CAPACITY];
    logic           ins_canc [CAPACITY];
    logic [63:0]    sel_dead;
    logic [63:0]    diff;
    logic [15:0]    wait_calc;
    logic           out_free;
    logic           head_due;
    logic           emit;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign cmd_ready = (state_reg == S_IDLE);
    assign head_due  = vld[0] && (dead_reg[0] <= time_reg);

    // a result beat is loaded into the output stage this cycle
    assign emit = out_free && ((state_reg == S_EMIT)
                  || (state_reg == S_POP && !(head_due && canc_reg[0])));

    // per-cell compares
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            vld[i] = (CW'(i) < count_reg);
            gt[i]  = vld[i] && (dead_reg[i] > dl_reg);
            due[i] = vld[i] && (dead_reg[i] <= time_reg);
        end
    end

    // sorted insert: later cells move up one place
    always_comb
    begin
        if (gt[0] || count_reg == '0)
        begin
            ins_dead[0] = dl_reg;
            ins_hdl[0]  = next_handle_reg;
            ins_canc[0] = 1'b0;
        end
        else
        begin
            ins_dead[0] = dead_reg[0];
            ins_hdl[0]  = hdl_reg[0];
            ins_canc[0] = canc_reg[0];
        end
        for (int i = 1; i < CAPACITY; i++)
        begin
            if (gt[i-1])
            begin
                ins_dead[i] = dead_reg[i-1];
                ins_hdl[i]  = hdl_reg[i-1];
                ins_canc[i] = canc_reg[i-1];
            end
            else if (gt[i] || count_reg == CW'(i))
            begin
                ins_dead[i] = dl_reg;
                ins_hdl[i]  = next_handle_reg;
                ins_canc[i] = 1'b0;
            end
            else
            begin
                ins_dead[i] = dead_reg[i];
                ins_hdl[i]  = hdl_reg[i];
                ins_canc[i] = canc_reg[i];
            end
        end
    end

    // head after the item: first cell not due on a tick, else cell 0
    always_comb
    begin
        sel_dead = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (op_reg == OP_TICK)
                sel[i] = vld[i] && !due[i] && ((i == 0) || due[(i == 0) ? 0 : i - 1]);
            else
                sel[i] = vld[i] && (i == 0);
            sel_dead = sel_dead | (sel[i] ? dead_reg[i] : 64'd0);
        end
        diff = sel_dead - time_reg;
        if (sel == '0)
            wait_calc = max_wait;
        else if (sel_dead <= time_reg)
            wait_calc = 16'd0;
        else if (diff > {48'd0, max_wait})
            wait_calc = max_wait;
        else
            wait_calc = diff[15:0];
    end

    // sequencer and result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            time_reg        <= '0;
            next_handle_reg <= '0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (emit)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        case (cmd.op)
                            OP_ADD:
                                state_reg <= (count_reg == CW'(CAPACITY)) ? S_WAIT : S_SUM;
                            OP_TICK:
                            begin
                                time_reg  <= time_reg + 64'd1;
                                state_reg <= S_WAIT;
                            end
                            OP_CANCEL:
                                state_reg <= S_EXEC;
                            default:
                                state_reg <= S_WAIT;
                        endcase
                    end
                end
                S_SUM:
                    state_reg <= S_INS;
                S_INS:
                begin
                    next_handle_reg <= next_handle_reg + 16'd1;
                    count_reg       <= count_reg + CW'(1);
                    state_reg       <= S_WAIT;
                end
                S_EXEC:
                    state_reg <= S_WAIT;
                S_WAIT:
                    state_reg <= (op_reg == OP_TICK) ? S_POP : S_EMIT;
                S_POP:
                begin
                    if (head_due)
                    begin
                        if (canc_reg[0] || out_free)
                            count_reg <= count_reg - CW'(1);
                    end
                    else if (out_free)
                        state_reg <= S_IDLE;
                end
                S_EMIT:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // payload: command latch, cells and result fields
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_reg          <= cmd.op;
                    delay_reg       <= cmd.timer_delay;
                    target_reg      <= cmd.target_handle;
                    pend_kind_reg   <= (cmd.op == OP_ADD) ? KIND_FULL : KIND_TICK;
                    pend_handle_reg <= 16'd0;
                end
            end
            S_SUM:
                dl_reg <= time_reg + {32'd0, delay_reg};
            S_INS:
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    dead_reg[i] <= ins_dead[i];
                    hdl_reg[i]  <= ins_hdl[i];
                    canc_reg[i] <= ins_canc[i];
                end
                pend_kind_reg   <= KIND_ADDED;
                pend_handle_reg <= next_handle_reg;
            end
            S_EXEC:
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (vld[i] && hdl_reg[i] == target_reg)
                        canc_reg[i] <= 1'b1;
                end
                pend_kind_reg   <= KIND_CANCEL;
                pend_handle_reg <= target_reg;
            end
            S_WAIT:
                wait_reg <= wait_calc;
            S_POP:
            begin
                if (head_due && (canc_reg[0] || out_free))
                begin
                    for (int i = 0; i < CAPACITY - 1; i++)
                    begin
                        dead_reg[i] <= dead_reg[i+1];
                        hdl_reg[i]  <= hdl_reg[i+1];
                        canc_reg[i] <= canc_reg[i+1];
                    end
                end
                if (out_free)
                begin
                    out_wait_reg <= wait_reg;
                    if (head_due)
                    begin
                        out_kind_reg   <= KIND_FIRED;
                        out_handle_reg <= hdl_reg[0];
                        out_last_reg   <= 1'b0;
                    end
                    else
                    begin
                        out_kind_reg   <= pend_kind_reg;
                        out_handle_reg <= pend_handle_reg;
                        out_last_reg   <= 1'b1;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_kind_reg   <= pend_kind_reg;
                    out_handle_reg <= pend_handle_reg;
                    out_wait_reg   <= wait_reg;
                    out_last_reg   <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.kind    = out_kind_reg;
    assign rsp.handle  = out_handle_reg;
    assign rsp.wait_ms = out_wait_reg;
    assign rsp.last    = out_last_reg;
endmodule
`default_nettype wire

// ----- hdl/deadline_timer_queue.sv -----
// Deadline timer queue. Keeps up to CAPACITY pending timers sorted by
// deadline (ties in insertion order) and a 64-bit millisecond clock. A
// request beat is decoded into a two-entry command queue; the back end runs
// one command at a time on a row of sorted cells: an add through sum,
// insert, wait and emit; cancel through sweep, wait, emit; rejected add or
// no-op through wait, emit; tick through wait, then a pop per due entry.
// One cell-row operation (insert, cancel sweep, or pop) per cycle, a pop of
// a live timer only while the output is free. No clearing pass after reset.
// ----------------------------------------------------------------------------
// deadline_timer_queue
// Top level: configuration register, front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module deadline_timer_queue #(
    parameter int CAPACITY = dtq_pkg::CAPACITY_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dtq_req_if.sink     req,
    dtq_rsp_if.source   rsp,
    dtq_cfg_if.sink     cfg
);
    import dtq_pkg::*;

    cmd_t        cmd;
    logic        cmd_valid;
    logic        cmd_ready;
    logic [15:0] max_wait_reg;

    // max_wait_ms register
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_wait_reg <= MAX_WAIT_RESET;
        else if (cfg.valid)
            max_wait_reg <= cfg.data;
    end

    dtq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready)
    );

    dtq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .max_wait  (max_wait_reg),
        .rsp       (rsp)
    );

    // result beat sanity
    `DTQ_ASSERT_IMP(a_added_last, clk, rst_n, rsp.valid && rsp.kind == KIND_ADDED, rsp.last)
    `DTQ_ASSERT_IMP(a_fired_not_last, clk, rst_n, rsp.valid && rsp.kind == KIND_FIRED, !rsp.last)
    `DTQ_ASSERT_IMP(a_full_no_handle, clk, rst_n, rsp.valid && rsp.kind == KIND_FULL, rsp.handle == 16'd0)
    `DTQ_ASSERT_NXT(a_cfg_taken, clk, rst_n, cfg.valid, max_wait_reg == $past(cfg.data))
endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the deadline timer queue: a directed table, then
// random commands under several idle/stall phases, with max_wait changes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module testbench;
    import dtq_pkg::*;

    localparam int CAP = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [2:0]  kind;
        logic [15:0] handle;
        logic [15:0] wait_ms;
        logic        last;
    } result_t;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] delay;
        logic [15:0] target;
        logic        has_exp;
        logic [2:0]  exp_kind;
        logic [15:0] exp_handle;
        logic [15:0] exp_wait;
    } row_t;

    logic clk;
    logic rst_n;
    dtq_req_if req ();
    dtq_rsp_if rsp ();
    dtq_cfg_if cfg ();

    deadline_timer_queue u_dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .cfg(cfg));

    // timer model state
    logic [63:0] now_ms;
    logic [15:0] handle_ctr;
    logic [63:0] slot_deadline [CAP];
    logic [15:0] slot_handle [CAP];
    logic        slot_dead [CAP];
    int          slot_count;
    logic [15:0] wait_cap;

    result_t expected_results [$];
    int  errors;
    int  beats_in;
    int  beats_out;
    int  idle_cycles;
    int  send_idle_pct;
    int  recv_stall_pct;
    row_t table_rows [$];

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [15:0] wait_value();
        logic [63:0] delta;
        if (slot_count == 0) return wait_cap;
        if (slot_deadline[0] <= now_ms) return 16'd0;
        delta = slot_deadline[0] - now_ms;
        return (delta > {48'd0, wait_cap}) ? wait_cap : delta[15:0];
    endfunction

    // advance the timer model by one command and queue its results
    task automatic predict_timers(input logic [1:0] mode, input logic [31:0] delay,
                                  input logic [15:0] target);
        result_t outs [$];
        result_t r;
        logic [63:0] dl;
        logic [15:0] w;
        logic        gone;
        logic [15:0] h;
        int          pos;
        r.wait_ms = 16'd0;
        r.last = 1'b0;
        if (mode == MODE_ADD) begin
            if (slot_count >= CAP) begin
                r.kind = KIND_FULL; r.handle = 16'd0; outs.push_back(r);
            end else begin
                dl = now_ms + {32'd0, delay};
                pos = slot_count;
                while (pos > 0 && slot_deadline[pos-1] > dl) begin
                    slot_deadline[pos] = slot_deadline[pos-1];
                    slot_handle[pos] = slot_handle[pos-1];
                    slot_dead[pos] = slot_dead[pos-1];
                    pos--;
                end
                slot_deadline[pos] = dl;
                slot_handle[pos] = handle_ctr;
                slot_dead[pos] = 1'b0;
                slot_count++;
                r.kind = KIND_ADDED; r.handle = handle_ctr; outs.push_back(r);
                handle_ctr = handle_ctr + 16'd1;
            end
        end else if (mode == MODE_TICK) begin
            now_ms = now_ms + 64'd1;
            while (slot_count > 0 && slot_deadline[0] <= now_ms) begin
                gone = slot_dead[0];
                h = slot_handle[0];
                for (int i = 1; i < slot_count; i++) begin
                    slot_deadline[i-1] = slot_deadline[i];
                    slot_handle[i-1] = slot_handle[i];
                    slot_dead[i-1] = slot_dead[i];
                end
                slot_count--;
                if (!gone) begin
                    r.kind = KIND_FIRED; r.handle = h; outs.push_back(r);
                end
            end
            r.kind = KIND_TICK; r.handle = 16'd0; outs.push_back(r);
        end else if (mode == MODE_CANCEL) begin
            for (int i = 0; i < slot_count; i++)
                if (slot_handle[i] == target) slot_dead[i] = 1'b1;
            r.kind = KIND_CANCEL; r.handle = target; outs.push_back(r);
        end else begin
            r.kind = KIND_TICK; r.handle = 16'd0; outs.push_back(r);
        end
        w = wait_value();
        foreach (outs[k]) begin
            outs[k].wait_ms = w;
            outs[k].last = (k == outs.size() - 1);
            expected_results.push_back(outs[k]);
        end
    endtask

    // send one command beat; optional typed-in single-result check
    task automatic send_cmd(input row_t row);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.mode <= row.mode;
        req.timer_delay <= row.delay;
        req.target_handle <= row.target;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        predict_timers(row.mode, row.delay, row.target);
        if (row.has_exp) begin
            result_t e;
            e = expected_results[expected_results.size() - 1];
            if (e.kind !== row.exp_kind || e.handle !== row.exp_handle
                || e.wait_ms !== row.exp_wait) begin
                $display("%0t table row mismatch: expected %0d/%0d/%0d actual %0d/%0d/%0d",
                         $time, row.exp_kind, row.exp_handle, row.exp_wait,
                         e.kind, e.handle, e.wait_ms);
                errors++;
            end
        end
        beats_in++;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        req.valid <= 1'b0;
        while (expected_results.size() > 0 && guard < WATCHDOG_LIMIT) begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
    endtask

    // register write while idle
    task automatic write_wait_cap(input logic [15:0] value);
        drain();
        cfg.valid <= 1'b1;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
        wait_cap = value;
    endtask

    function automatic row_t mk(input logic [1:0] m, input logic [31:0] d,
                                input logic [15:0] t);
        row_t r;
        r.mode = m; r.delay = d; r.target = t; r.has_exp = 1'b0;
        r.exp_kind = 3'd0; r.exp_handle = 16'd0; r.exp_wait = 16'd0;
        return r;
    endfunction

    function automatic row_t mkx(input logic [1:0] m, input logic [31:0] d,
                                 input logic [15:0] t, input logic [2:0] k,
                                 input logic [15:0] h, input logic [15:0] w);
        row_t r;
        r = mk(m, d, t);
        r.has_exp = 1'b1; r.exp_kind = k; r.exp_handle = h; r.exp_wait = w;
        return r;
    endfunction

    function automatic row_t rand_row();
        int pick;
        logic [31:0] d;
        pick = $urandom_range(99, 0);
        case ($urandom_range(3, 0))
            0: d = $urandom();
            1: d = $urandom_range(40, 0);
            default: d = $urandom_range(8, 0);
        endcase
        if (pick < 40) return mk(MODE_ADD, d, 16'd0);
        if (pick < 80) return mk(MODE_TICK, $urandom(), 16'($urandom()));
        if (pick < 95) return mk(MODE_CANCEL, $urandom(),
                                 ($urandom_range(3, 0) == 0) ? 16'($urandom())
                                 : handle_ctr - 16'($urandom_range(8, 1)));
        return mk(MODE_NOP, $urandom(), 16'($urandom()));
    endfunction

    // result checker and receiver stalls
    always @(posedge clk)
    begin
        result_t e;
        if (rsp.valid && rsp.ready) begin
            beats_out++;
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result: kind %0d handle %0d", $time,
                         rsp.kind, rsp.handle);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (rsp.kind !== e.kind || rsp.handle !== e.handle
                    || rsp.wait_ms !== e.wait_ms || rsp.last !== e.last) begin
                    $display("%0t result mismatch: expected k%0d h%0d w%0d l%0d actual k%0d h%0d w%0d l%0d",
                             $time, e.kind, e.handle, e.wait_ms, e.last,
                             rsp.kind, rsp.handle, rsp.wait_ms, rsp.last);
                    errors++;
                end
            end
        end
        rsp.ready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
    end

    // watchdog on cycles with no beat
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int pass;
        row_t row;
        errors = 0; beats_in = 0; beats_out = 0; idle_cycles = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        now_ms = 64'd0; handle_ctr = 16'd0; slot_count = 0; wait_cap = MAX_WAIT_RESET;
        rst_n = 1'b0;
        req.valid = 1'b0; req.mode = MODE_ADD; req.timer_delay = 32'd0;
        req.target_handle = 16'd0;
        rsp.ready = 1'b1;
        cfg.valid = 1'b0; cfg.data = 16'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        table_rows.push_back(mkx(MODE_TICK, 32'd0, 16'd0, KIND_TICK, 16'd0, 16'd1000));
        table_rows.push_back(mkx(MODE_NOP, 32'd0, 16'd0, KIND_TICK, 16'd0, 16'd1000));
        table_rows.push_back(mkx(MODE_CANCEL, 32'd0, 16'hFFFF, KIND_CANCEL, 16'hFFFF, 16'd1000));
        table_rows.push_back(mkx(MODE_ADD, 32'd0, 16'd0, KIND_ADDED, 16'd0, 16'd0));
        table_rows.push_back(mk(MODE_ADD, 32'hFFFF_FFFF, 16'hFFFF));
        table_rows.push_back(mk(MODE_ADD, 32'd2, 16'd0));
        table_rows.push_back(mk(MODE_ADD, 32'd2, 16'd0));
        table_rows.push_back(mk(MODE_CANCEL, 32'd0, 16'd2));
        table_rows.push_back(mk(MODE_TICK, 32'd0, 16'd0));
        table_rows.push_back(mk(MODE_TICK, 32'd0, 16'd0));
        for (int i = 0; i < 15; i++)
            table_rows.push_back(mk(MODE_ADD, 32'd5 + i, 16'd0));
        table_rows.push_back(mkx(MODE_ADD, 32'd1, 16'd0, KIND_FULL, 16'd0, 16'd5));
        foreach (table_rows[i]) send_cmd(table_rows[i]);
        repeat (20) send_cmd(mk(MODE_TICK, 32'd0, 16'd0));

        // random phases across idle patterns and register settings
        for (pass = 0; pass < 5; pass++) begin
            case (pass)
                0: write_wait_cap(16'd0);
                1: write_wait_cap(16'hFFFF);
                2: write_wait_cap(16'd7);
                3: write_wait_cap(16'($urandom()));
                default: write_wait_cap(MAX_WAIT_RESET);
            endcase
            send_idle_pct = (pass == 1 || pass == 3) ? 69 : 0;
            recv_stall_pct = (pass == 2 || pass == 3) ? 69 : 0;
            if (pass == 3) begin
                send_idle_pct = 12; recv_stall_pct = 12;
            end
            if (pass == 4) send_idle_pct = 69;
            for (int n = 0; n < 80; n++) begin
                row = rand_row();
                send_cmd(row);
            end
        end

        // an add with the largest 32-bit delay, far beyond max_wait, then drain
        send_cmd(mk(MODE_ADD, 32'hFFFF_FFFF, 16'd0));
        drain();
        recv_stall_pct = 0;
        repeat (20) @(posedge clk);
        $display("Sent %0d commands, checked %0d result beats over five idle/stall phases",
                 beats_in, beats_out);
        if (errors == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/dtq_pkg.sv
hdl/dtq_req_if.sv
hdl/dtq_rsp_if.sv
hdl/dtq_cfg_if.sv
hdl/dtq_front.sv
hdl/dtq_back.sv
hdl/deadline_timer_queue.sv
verif/testbench.sv
